/* hdl/snp_pkg.sv */
// ----------------------------------------------------------------------------
// snp_pkg
// Shared types and constants for the snapshot history interpolator.
// ----------------------------------------------------------------------------
package snp_pkg;

    // input kind codes
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // 1/64 degree units
    localparam int ANGLE_FULL = 23040;
    localparam int ANGLE_HALF = 11520;

    localparam logic [15:0] DELAY_RESET = 16'd100;

    // command handed from front to back; tq is the push time or the query time
    typedef struct packed {
        logic [1:0]         op;
        logic signed [32:0] tq;
        logic [31:0]        x;
        logic [31:0]        y;
        logic [31:0]        z;
        logic [15:0]        yaw;
        logic [15:0]        pitch;
    } cmd_t;

    // one stored snapshot
    typedef struct packed {
        logic [31:0] tm;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] yaw;
        logic [15:0] pitch;
    } entry_t;

endpackage

/* hdl/snp_ram.sv */
// ----------------------------------------------------------------------------
// snp_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module snp_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/snp_queue.sv */
// ----------------------------------------------------------------------------
// snp_queue
// Two entry FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module snp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wptr_next = do_push ? ~wptr_reg : wptr_reg;
        rptr_next = do_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/snp_front.sv */
// ----------------------------------------------------------------------------
// snp_front
// Holds the render delay, classifies items and forms back-end commands.
// ----------------------------------------------------------------------------
module snp_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [31:0]        s_time_ms,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [15:0] s_yaw_in,
    input  logic signed [15:0] s_pitch_in,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output snp_pkg::cmd_t      cmd
);

    logic [15:0] delay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= snp_pkg::DELAY_RESET;
        end else if (cfg_we) begin
            delay_reg <= cfg_wdata;
        end
    end

    // unknown kind is swallowed here and never reaches the back
    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid && (s_kind != snp_pkg::KIND_NONE);

    always_comb begin
        cmd.op    = s_kind;
        cmd.tq    = (s_kind == snp_pkg::KIND_QUERY)
                  ? $signed({1'b0, s_time_ms} - {17'd0, delay_reg})
                  : $signed({1'b0, s_time_ms});
        cmd.x     = s_pos_x;
        cmd.y     = s_pos_y;
        cmd.z     = s_pos_z;
        cmd.yaw   = s_yaw_in;
        cmd.pitch = s_pitch_in;
    end

endmodule

/* hdl/snp_back.sv */
// ----------------------------------------------------------------------------
// snp_back
// Executes commands: history ring writes, search, divide and blend.
// ----------------------------------------------------------------------------
module snp_back #(
    parameter int HISTORY_DEPTH = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  snp_pkg::cmd_t      cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_has_data,
    output logic signed [31:0] m_out_pos_x,
    output logic signed [31:0] m_out_pos_y,
    output logic signed [31:0] m_out_pos_z,
    output logic signed [16:0] m_out_yaw,
    output logic signed [16:0] m_out_pitch
);

    localparam int IW  = $clog2(HISTORY_DEPTH);
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int DCW = $clog2(FRACTION_BITS + 1);
    localparam int PW  = 35 + FRACTION_BITS;
    localparam int EW  = $bits(snp_pkg::entry_t);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [IW-1:0]          oldest_reg, oldest_next;
    logic [CW-1:0]          idx_reg, idx_next;
    snp_pkg::cmd_t          cmd_reg, cmd_next;
    snp_pkg::entry_t        lo_reg, lo_next, hi_reg, hi_next, rd_entry;
    logic signed [32:0]     span_reg, span_next;
    logic [33:0]            rem_reg, rem_next;
    logic [FRACTION_BITS:0] t_reg, t_next;
    logic [DCW-1:0]         dcnt_reg, dcnt_next;
    logic [2:0]             j_reg, j_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic [31:0]            res_reg [5];
    logic [31:0]            res_next [5];
    logic                   has_reg, has_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr, ram_raddr;
    logic [EW-1:0]          ram_rdata;

    snp_ram #(.WIDTH(EW), .DEPTH(HISTORY_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (EW'({cmd.tq[31:0], cmd.x, cmd.y, cmd.z, cmd.yaw, cmd.pitch})),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = snp_pkg::entry_t'(ram_rdata);

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] oldest,
                                              input logic [CW-1:0] i);
        logic [CW:0] s;
        s = (CW+1)'(oldest) + (CW+1)'(i);
        if (s >= (CW+1)'(HISTORY_DEPTH)) begin
            s = s - (CW+1)'(HISTORY_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    // shortest path angle difference, truncated modulo a full turn
    function automatic logic signed [17:0] angle_delta(input logic [15:0] from,
                                                       input logic [15:0] to);
        logic signed [17:0] diff;
        logic [16:0]        a;
        logic signed [17:0] r;
        diff = $signed({{2{to[15]}}, to}) - $signed({{2{from[15]}}, from});
        a    = diff[17] ? 17'(-diff) : diff[16:0];
        if (a >= 17'(2 * snp_pkg::ANGLE_FULL)) begin
            a = a - 17'(2 * snp_pkg::ANGLE_FULL);
        end else if (a >= 17'(snp_pkg::ANGLE_FULL)) begin
            a = a - 17'(snp_pkg::ANGLE_FULL);
        end
        r = diff[17] ? -$signed({1'b0, a}) : $signed({1'b0, a});
        if (r > 18'sd11520) begin
            r = r - 18'(snp_pkg::ANGLE_FULL);
        end else if (r < -18'sd11520) begin
            r = r + 18'(snp_pkg::ANGLE_FULL);
        end
        return r;
    endfunction

    logic signed [33:0] cmp_q, cmp_t, num;
    logic signed [32:0] span_c;
    logic [33:0]        r2;
    logic               hit;
    logic signed [32:0] d_op;
    logic signed [31:0] base_op;
    logic signed [PW-1:0] sum_c;

    always_comb begin
        cmp_q  = {cmd_reg.tq[32], cmd_reg.tq};
        cmp_t  = $signed({2'b00, rd_entry.tm});
        hit    = cmp_t >= cmp_q;
        span_c = $signed({1'b0, rd_entry.tm}) - $signed({1'b0, hi_reg.tm});
        num    = cmp_q - $signed({2'b00, hi_reg.tm});
        r2     = {rem_reg[32:0], 1'b0};

        unique case (j_reg)
            3'd0:    d_op = $signed({hi_reg.x[31], hi_reg.x}) - $signed({lo_reg.x[31], lo_reg.x});
            3'd1:    d_op = $signed({hi_reg.y[31], hi_reg.y}) - $signed({lo_reg.y[31], lo_reg.y});
            3'd2:    d_op = $signed({hi_reg.z[31], hi_reg.z}) - $signed({lo_reg.z[31], lo_reg.z});
            3'd3:    d_op = 33'(angle_delta(lo_reg.yaw, hi_reg.yaw));
            default: d_op = 33'(angle_delta(lo_reg.pitch, hi_reg.pitch));
        endcase
        unique case (j_reg)
            3'd0:    base_op = lo_reg.x;
            3'd1:    base_op = lo_reg.y;
            3'd2:    base_op = lo_reg.z;
            3'd3:    base_op = 32'($signed(lo_reg.yaw));
            default: base_op = 32'($signed(lo_reg.pitch));
        endcase
        sum_c = PW'(base_op) + (prod_reg >>> FRACTION_BITS);
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        oldest_next    = oldest_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        t_next         = t_reg;
        dcnt_next      = dcnt_reg;
        j_next         = j_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        has_next       = has_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd_ready      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = (count_reg >= CW'(HISTORY_DEPTH)) ? oldest_reg
                                                           : slot_of(oldest_reg, count_reg);
        ram_raddr      = slot_of(oldest_reg, idx_reg);

        unique case (state_reg)
            S_IDLE: begin
                cmd_ready = 1'b1;
                cmd_next  = cmd;
                if (cmd_valid) begin
                    priority case (cmd.op)
                        snp_pkg::KIND_PUSH: begin
                            ram_we = 1'b1;
                            if (count_reg >= CW'(HISTORY_DEPTH)) begin
                                oldest_next = slot_of(oldest_reg, CW'(1));
                            end else begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        snp_pkg::KIND_CLEAR: begin
                            count_next  = '0;
                            oldest_next = '0;
                        end
                        default: begin
                            idx_next = '0;
                            if (count_reg == '0) begin
                                has_next = 1'b0;
                                for (int k = 0; k < 5; k++) res_next[k] = '0;
                                state_next = S_EMIT;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                hi_next = rd_entry;
                if (hit && idx_reg != '0) begin
                    lo_next   = hi_reg;
                    span_next = span_c;
                    rem_next  = num;
                    t_next    = '0;
                    dcnt_next = '0;
                    j_next    = '0;
                    if (span_c <= 0 || num >= 34'(span_c)) begin
                        t_next     = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
                        state_next = S_MUL;
                    end else if (num <= 0) begin
                        state_next = S_MUL;
                    end else begin
                        state_next = S_DIV;
                    end
                end else if (hit || idx_reg == count_reg - CW'(1)) begin
                    // nearest snapshot, unchanged
                    has_next    = 1'b1;
                    res_next[0] = rd_entry.x;
                    res_next[1] = rd_entry.y;
                    res_next[2] = rd_entry.z;
                    res_next[3] = 32'($signed(rd_entry.yaw));
                    res_next[4] = 32'($signed(rd_entry.pitch));
                    state_next  = S_EMIT;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_RD;
                end
            end
            S_DIV: begin
                if (r2 >= {1'b0, span_reg}) begin
                    rem_next = r2 - {1'b0, span_reg};
                    t_next   = {t_reg[FRACTION_BITS-1:0], 1'b1};
                end else begin
                    rem_next = r2;
                    t_next   = {t_reg[FRACTION_BITS-1:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(FRACTION_BITS - 1)) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = PW'(d_op) * PW'($signed({1'b0, t_reg}));
                state_next = S_ADD;
            end
            S_ADD: begin
                res_next[j_reg] = sum_c[31:0];
                has_next        = 1'b1;
                j_next          = j_reg + 3'd1;
                state_next      = (j_reg == 3'd4) ? S_EMIT : S_MUL;
            end
            S_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        cmd_reg  <= cmd_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        span_reg <= span_next;
        rem_reg  <= rem_next;
        t_reg    <= t_next;
        dcnt_reg <= dcnt_next;
        j_reg    <= j_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        has_reg  <= has_next;
    end

    logic               m_has_reg;
    logic signed [31:0] m_x_reg, m_y_reg, m_z_reg;
    logic signed [16:0] m_yaw_reg, m_pitch_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT && (!out_valid_reg || m_ready)) begin
            m_has_reg   <= has_reg;
            m_x_reg     <= res_reg[0];
            m_y_reg     <= res_reg[1];
            m_z_reg     <= res_reg[2];
            m_yaw_reg   <= res_reg[3][16:0];
            m_pitch_reg <= res_reg[4][16:0];
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_has_data  = m_has_reg;
    assign m_out_pos_x = m_x_reg;
    assign m_out_pos_y = m_y_reg;
    assign m_out_pos_z = m_z_reg;
    assign m_out_yaw   = m_yaw_reg;
    assign m_out_pitch = m_pitch_reg;

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(HISTORY_DEPTH)) else $error("history count overflow");
    a_oldest_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        oldest_reg < IW'(HISTORY_DEPTH - 1) || oldest_reg == IW'(HISTORY_DEPTH - 1))
        else $error("oldest slot out of range");
    a_div_span: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> span_reg > 0) else $error("divide with nonpositive span");
    a_wrap_full: assert property (@(posedge aclk) disable iff (!aresetn)
        oldest_reg != '0 |-> count_reg == CW'(HISTORY_DEPTH))
        else $error("ring wrapped before full");

endmodule

/* hdl/snapshot_history_interpolator.sv */
// ----------------------------------------------------------------------------
// snapshot_history_interpolator
// Ring of timestamped snapshots answering delayed interpolation queries.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel (valid/ready) carries items: push a snapshot, query, or
//   clear. A query returns one item on the m_* channel holding the state at
//   s_time_ms minus render delay; pushes and clears return nothing, kind 3
//   is dropped at the input.
//   cfg_we/cfg_wdata write the render delay (reset 100 ms), idle only.
// Operation:
//   The front takes an item whenever the two entry queue has room. The back
//   runs one item at a time. A query walks the ring oldest first, each entry
//   a registered RAM read (S_RD) then a compare (S_CMP); unless the blend
//   factor is 0 or 1 it then runs a restoring divide for FRACTION_BITS
//   quotient bits, then the five fields share one multiplier (S_MUL then
//   S_ADD per field), then S_EMIT hands off. An empty ring goes to S_EMIT.
// Reset clears count, ring pointer and queue; RAM contents are not cleared.
// A stalled receiver holds the result in the output register; the back
// waits on the next result only, while the queue takes items until full.
// ----------------------------------------------------------------------------
module snapshot_history_interpolator #(
    parameter int HISTORY_DEPTH = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [31:0]        s_time_ms,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [15:0] s_yaw_in,
    input  logic signed [15:0] s_pitch_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_has_data,
    output logic signed [31:0] m_out_pos_x,
    output logic signed [31:0] m_out_pos_y,
    output logic signed [31:0] m_out_pos_z,
    output logic signed [16:0] m_out_yaw,
    output logic signed [16:0] m_out_pitch
);

    localparam int CMDW = $bits(snp_pkg::cmd_t);

    logic          f_valid, f_ready;
    snp_pkg::cmd_t f_cmd;
    logic          b_valid, b_ready;
    logic [CMDW-1:0] b_bits;

    // front: delay register and item classification
    snp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_time_ms  (s_time_ms),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_pos_z    (s_pos_z),
        .s_yaw_in   (s_yaw_in),
        .s_pitch_in (s_pitch_in),
        .cmd_valid  (f_valid),
        .cmd_ready  (f_ready),
        .cmd        (f_cmd)
    );

    // command queue between the two sides
    snp_queue #(.WIDTH(CMDW)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (CMDW'(f_cmd)),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_bits)
    );

    // back: history ring, search, divide, blend, output register
    snp_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (b_valid),
        .cmd_ready   (b_ready),
        .cmd         (snp_pkg::cmd_t'(b_bits)),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_has_data  (m_has_data),
        .m_out_pos_x (m_out_pos_x),
        .m_out_pos_y (m_out_pos_y),
        .m_out_pos_z (m_out_pos_z),
        .m_out_yaw   (m_out_yaw),
        .m_out_pitch (m_out_pitch)
    );

endmodule
